FILE: sv/max_profit_k_transactions_top_defines.svh
`ifndef MAX_PROFIT_K_TRANSACTIONS_TOP_DEFINES_SVH
`define MAX_PROFIT_K_TRANSACTIONS_TOP_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define MPK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define MPK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mpk_pkg.sv
`default_nettype none

package mpk_pkg;

    localparam int MAX_TRANS_DEF  = 16;
    localparam int PRICE_BITS_DEF = 16;
    localparam int PRICE_W        = 16;
    localparam int PROFIT_W       = 20;
    localparam int K_W            = 5;
    localparam logic [K_W-1:0] K_RESET = 5'd1;

    typedef struct packed {
        logic en;
        logic clr;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: sv/mpk_cell.sv
`default_nettype none

module mpk_cell
    import mpk_pkg::*;
#(
    parameter int PB = PRICE_BITS_DEF,
    parameter int W  = PRICE_BITS_DEF + 7
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire logic [PB-1:0]       i_price,
    input  wire logic signed [W-1:0] i_prev_sale,
    output logic signed [W-1:0]      o_sale,
    output logic signed [W-1:0]      o_sale_next
);

    localparam logic signed [W-1:0] HOLD_NONE = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_hold;
    logic signed [W-1:0] r_sale;
    logic signed [W-1:0] n_hold;
    logic signed [W-1:0] n_sale;
    logic signed [W-1:0] w_price;
    logic signed [W-1:0] w_buy;
    logic signed [W-1:0] w_sell;

    always_comb begin
        w_price = $signed(W'(i_price));
        w_buy   = i_prev_sale - w_price;
        w_sell  = r_hold + w_price;
        n_hold  = (w_buy > r_hold) ? w_buy : r_hold;
        n_sale  = (w_sell > r_sale) ? w_sell : r_sale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_NONE;
            r_sale <= '0;
        end else if (i_ctrl.en) begin
            if (i_ctrl.clr) begin
                r_hold <= HOLD_NONE;
                r_sale <= '0;
            end else begin
                r_hold <= n_hold;
                r_sale <= n_sale;
            end
        end
    end

    assign o_sale      = r_sale;
    assign o_sale_next = n_sale;

endmodule

`default_nettype wire

FILE: sv/max_profit_k_transactions_top.sv
// Channel   Direction  Handshake                 Payload
// in        request    i_in_valid / o_in_stall   i_price, i_last_day
// out       result     o_out_valid / i_out_stall o_max_profit
// cfg       write      i_cfg_valid / o_cfg_ready i_cfg_max_transactions
//
// One price is taken per cycle unless stalled; each cell does two adds and two compares.
// A result appears in the output register in the cycle after its last-day price is taken.
// Reset is synchronous; it clears all cells and sets the transaction count to one.
// The input stalls only while a finished result is held and the output is stalled.
`default_nettype none

`include "max_profit_k_transactions_top_defines.svh"

module max_profit_k_transactions_top
    import mpk_pkg::*;
#(
    parameter int MAX_TRANS  = MAX_TRANS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [PRICE_W-1:0]  i_price,
    input  wire logic                i_last_day,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [PROFIT_W-1:0]      o_max_profit,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [K_W-1:0]      i_cfg_max_transactions
);

    localparam int PE    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int W     = PE + $clog2(MAX_TRANS + 1) + 2;
    localparam int KI_W  = $clog2(MAX_TRANS + 1);
    localparam int EXT_W = (W > PROFIT_W) ? W : PROFIT_W;

    logic [K_W-1:0]      r_k;
    logic                r_out_valid;
    logic [PROFIT_W-1:0] r_max_profit;
    logic                w_accept;
    t_cell_ctrl          w_ctrl;
    logic [PE-1:0]       w_price;
    logic [KI_W-1:0]     w_kidx;
    logic signed [W-1:0] w_sale [0:MAX_TRANS];
    logic signed [W-1:0] w_sale_next [0:MAX_TRANS];
    logic signed [W-1:0] w_sel;
    logic [EXT_W-1:0]    w_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_price     = i_price[PE-1:0];
    assign w_ctrl.en   = w_accept;
    assign w_ctrl.clr  = i_last_day;

    assign w_sale[0]      = '0;
    assign w_sale_next[0] = '0;

    for (genvar j = 1; j <= MAX_TRANS; j++) begin : g_cell
        mpk_cell #(
            .PB (PE),
            .W  (W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_price     (w_price),
            .i_prev_sale (w_sale[j-1]),
            .o_sale      (w_sale[j]),
            .o_sale_next (w_sale_next[j])
        );
    end

    always_comb begin
        if (32'(r_k) > MAX_TRANS) begin
            w_kidx = KI_W'(MAX_TRANS);
        end else begin
            w_kidx = KI_W'(r_k);
        end
        w_sel = w_sale_next[w_kidx];
        w_ext = EXT_W'($unsigned(w_sel));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_k <= i_cfg_max_transactions;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last_day) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_day) begin
            r_max_profit <= w_ext[PROFIT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_max_profit = r_max_profit;

    `MPK_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_accept && i_last_day,
        o_out_valid, "A last-day request did not produce a result.")
    `MPK_ASSERT_NEXT(a_last_clears_cells, i_clk, i_rst_n, w_accept && i_last_day,
        w_sale[1] == '0, "The cells were not cleared after a last-day request.")
    `MPK_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
        r_out_valid, "The input stalled without a held result.")
    `MPK_ASSERT_NEXT(a_zero_k_zero_profit, i_clk, i_rst_n,
        w_accept && i_last_day && (r_k == '0),
        o_max_profit == '0, "A transaction count of zero gave a nonzero profit.")

endmodule

`default_nettype wire

FILE: tb/max_profit_k_transactions_top_tb.sv
`timescale 1ns / 1ps

module max_profit_k_transactions_top_tb;
    import mpk_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam longint HOLD_NONE = -(64'sd1 <<< 60);

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [PRICE_W-1:0]  i_price = '0;
    logic                i_last_day = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [PROFIT_W-1:0] o_max_profit;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [K_W-1:0]      i_cfg_max_transactions = '0;

    logic [K_W-1:0]      k_setting;
    longint              hold_val[1:MAX_TRANS_DEF];
    longint              sale_val[0:MAX_TRANS_DEF];
    logic [PROFIT_W-1:0] profit_queue[$];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          hold_len = 0;
    logic        holding = 1'b0;
    event        hold_go;

    max_profit_k_transactions_top uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_price                (i_price),
        .i_last_day             (i_last_day),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_max_profit           (o_max_profit),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_max_transactions (i_cfg_max_transactions)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_trades();
        for (int j = 0; j <= MAX_TRANS_DEF; j++) begin
            if (j > 0) begin
                hold_val[j] = HOLD_NONE;
            end
            sale_val[j] = 0;
        end
    endfunction

    function automatic void advance_day(input logic [PRICE_W-1:0] price, input logic last,
                                        output bit has_result,
                                        output logic [PROFIT_W-1:0] profit);
        longint old_sale[0:MAX_TRANS_DEF];
        longint old_hold;
        longint p;
        int     kk;
        p = price;
        old_sale = sale_val;
        for (int j = 1; j <= MAX_TRANS_DEF; j++) begin
            old_hold = hold_val[j];
            hold_val[j] = (old_sale[j-1] - p > old_hold) ? old_sale[j-1] - p : old_hold;
            sale_val[j] = (old_hold + p > old_sale[j]) ? old_hold + p : old_sale[j];
        end
        has_result = last;
        profit = '0;
        if (last) begin
            kk = (k_setting > MAX_TRANS_DEF) ? MAX_TRANS_DEF : int'(k_setting);
            profit = sale_val[kk][PROFIT_W-1:0];
            clear_trades();
        end
    endfunction

    task automatic send_day(input logic [PRICE_W-1:0] price, input logic last);
        bit                  has_result;
        logic [PROFIT_W-1:0] profit;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_price    <= price;
        i_last_day <= last;
        do @(posedge i_clk); while (o_in_stall);
        advance_day(price, last, has_result, profit);
        if (has_result) begin
            profit_queue.push_back(profit);
        end
    endtask

    task automatic write_max_transactions(input logic [K_W-1:0] value);
        i_in_valid <= 1'b0;
        while (profit_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_max_transactions <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        k_setting = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (profit_queue.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("Unexpected result: max_profit %0d", o_max_profit);
                end
            end else begin
                if (o_max_profit !== profit_queue[0]) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("max_profit mismatch: expected %0d, got %0d",
                                 profit_queue[0], o_max_profit);
                    end
                end
                void'(profit_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_go);
            holding <= 1'b1;
            repeat (hold_len) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[max_profit_k_transactions_top] ERROR");
        $finish;
    end

    task automatic test_default_count();
        send_day(16'd10, 1'b0);
        send_day(16'd3, 1'b0);
        send_day(16'hFFFF, 1'b1);
        send_day(16'd500, 1'b1);
    endtask

    task automatic test_price_extremes();
        write_max_transactions(5'd2);
        send_day(16'h0000, 1'b0);
        send_day(16'hFFFF, 1'b0);
        send_day(16'h0000, 1'b0);
        send_day(16'hFFFF, 1'b1);
        send_day(16'hFFFF, 1'b0);
        send_day(16'h0000, 1'b1);
    endtask

    task automatic test_zero_transactions();
        write_max_transactions(5'd0);
        send_day(16'd5, 1'b0);
        send_day(16'hFFFF, 1'b1);
    endtask

    task automatic test_count_above_limit();
        write_max_transactions(5'd31);
        for (int i = 0; i < 32; i++) begin
            send_day(i[0] ? 16'hFFFF : 16'h0000, i == 31);
        end
    endtask

    task automatic test_count_change_midsequence();
        write_max_transactions(5'd1);
        send_day(16'd100, 1'b0);
        send_day(16'd900, 1'b0);
        send_day(16'd50, 1'b0);
        write_max_transactions(5'd3);
        send_day(16'd700, 1'b0);
        send_day(16'd20, 1'b0);
        send_day(16'd800, 1'b1);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        hold_len = 150;
        -> hold_go;
        for (int i = 0; i < 40; i++) begin
            send_day(16'($urandom), $urandom_range(3) != 0 || i == 39);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int                 sent;
        int                 next_cfg;
        int                 len;
        int                 style;
        logic [PRICE_W-1:0] base;
        logic [PRICE_W-1:0] price;
        send_idle_pct   = send_pct;
        recv_stall_pct <= recv_pct;
        sent = 0;
        next_cfg = 0;
        while (sent < n_items) begin
            if (sent >= next_cfg) begin
                write_max_transactions(($urandom_range(3) == 0) ? K_W'($urandom_range(31))
                                                                : K_W'($urandom_range(1, 16)));
                next_cfg = sent + 60;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
            style = $urandom_range(2);
            base = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                case (style)
                    0: begin
                        price = 16'($urandom);
                    end
                    1: begin
                        price = base + 16'($urandom_range(2000)) - 16'd1000;
                    end
                    default: begin
                        price = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    end
                endcase
                send_day(price, i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        k_setting = K_RESET;
        clear_trades();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_count();
        test_price_extremes();
        test_zero_transactions();
        test_count_above_limit();
        test_count_change_midsequence();
        test_output_backpressure();
        test_random_traffic(0, 0, 150);
        test_random_traffic(75, 0, 150);
        test_random_traffic(0, 75, 150);
        test_random_traffic(22, 22, 150);

        i_in_valid <= 1'b0;
        while (profit_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && profit_queue.size() == 0) begin
            $display("[max_profit_k_transactions_top] OK");
        end else begin
            $display("[max_profit_k_transactions_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/mpk_pkg.sv
sv/mpk_cell.sv
sv/max_profit_k_transactions_top.sv
tb/max_profit_k_transactions_top_tb.sv
